@@ hw/rtl/encoder_tunable_white_dimmer_macros.svh @@
// Assertion macros shared by the encoder dimmer RTL.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ENCODER_TUNABLE_WHITE_DIMMER_MACROS_SVH
`define ENCODER_TUNABLE_WHITE_DIMMER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ETWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ETWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/etwd_pkg.sv @@
// Shared types and constants of the encoder dimmer.
// No dependencies; used by every module of the block.
`default_nettype none

package etwd_pkg;

  localparam int unsigned MinPosition = 0;
  localparam logic [7:0]  MinPos8     = 8'(MinPosition);

  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
  localparam int unsigned DivW       = 16;
  localparam int unsigned DivCntW    = $clog2(DivW);

  localparam logic CmdTick = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POSITION_MAX   = 3'd0,
    CFG_LOW_STEP       = 3'd1,
    CFG_HIGH_STEP      = 3'd2,
    CFG_STEP_THRESHOLD = 3'd3,
    CFG_WARM_START     = 3'd4,
    CFG_WARM_STOP      = 3'd5,
    CFG_COOL_START     = 3'd6,
    CFG_COOL_STOP      = 3'd7
  } etwd_cfg_idx_e;

  typedef struct packed {
    logic [7:0] position_max;
    logic [7:0] low_step;
    logic [7:0] high_step;
    logic [7:0] step_threshold;
    logic [7:0] warm_start;
    logic [7:0] warm_stop;
    logic [7:0] cool_start;
    logic [7:0] cool_stop;
  } etwd_cfg_t;

  localparam etwd_cfg_t CfgReset = '{
    position_max:   8'd255,
    low_step:       8'd1,
    high_step:      8'd5,
    step_threshold: 8'd32,
    warm_start:     8'd0,
    warm_stop:      8'd192,
    cool_start:     8'd128,
    cool_stop:      8'd255
  };

  typedef struct packed {
    logic command;
    logic a_level;
    logic b_level;
    logic button_level;
  } etwd_item_t;

  typedef struct packed {
    logic [7:0] position;
    logic       lamp_on;
    logic [7:0] warm_target;
    logic [7:0] cool_target;
    logic [7:0] warm_level;
    logic [7:0] cool_level;
  } etwd_result_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_UP   = 2'd1,
    OP_DOWN = 2'd2,
    OP_TICK = 2'd3
  } etwd_op_e;

  typedef struct packed {
    etwd_op_e kind;
    logic     toggle;
  } etwd_op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } etwd_queue_stat_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [7:0]      divisor;
  } etwd_div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
  } etwd_div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_APPLY    = 5'b00010,
    S_CH_START = 5'b00100,
    S_CH_WAIT  = 5'b01000,
    S_DONE     = 5'b10000
  } etwd_state_e;

endpackage

`default_nettype wire

@@ hw/rtl/encoder_tunable_white_dimmer.sv @@
// Top level of the rotary encoder tunable-white dimmer.
// Depends on etwd_pkg, etwd_front, etwd_queue, etwd_div and etwd_back.
`default_nettype none

// Each input word is a pin-change event or a ramp tick and produces exactly one
// result word. A two-entry queue sits between the input side and the processing
// engine, so input words keep being taken while a result waits to be collected.
// The engine handles one word at a time: it takes, applies and finishes it,
// starts the warm and then the cool channel, and, for each channel whose
// target needs the linear map, waits on the shared bit-serial divider, which
// works out sixteen quotient bits and then raises done; a result may also
// wait on a stall before it is collected.
// Configuration writes are always ready and take effect on the next clock.
module encoder_tunable_white_dimmer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         item_valid_i,
  output logic                              item_stall_o,
  input  wire etwd_pkg::etwd_item_t         item_i,
  output logic                              result_valid_o,
  input  wire logic                         result_stall_i,
  output etwd_pkg::etwd_result_t            result_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [etwd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                   cfg_data_i
);

  etwd_pkg::etwd_op_t         push_op, head_op;
  etwd_pkg::etwd_queue_stat_t q_stat;
  etwd_pkg::etwd_div_req_t    div_req;
  etwd_pkg::etwd_div_rsp_t    div_rsp;
  logic push, pop;

  etwd_front u_front (
    .item_valid_i (item_valid_i),
    .item_stall_o (item_stall_o),
    .item_i       (item_i),
    .q_full_i     (q_stat.full),
    .push_o       (push),
    .op_o         (push_op)
  );

  etwd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (push_op),
    .pop_i  (pop),
    .op_o   (head_op),
    .stat_o (q_stat)
  );

  etwd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  etwd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .q_stat_i       (q_stat),
    .q_op_i         (head_op),
    .pop_o          (pop),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/etwd_front.sv @@
// Front end: takes input words and classifies them into queue operations.
// Depends on etwd_pkg.
`default_nettype none

module etwd_front (
  input  wire logic                 item_valid_i,
  output logic                      item_stall_o,
  input  wire etwd_pkg::etwd_item_t item_i,
  input  wire logic                 q_full_i,
  output logic                      push_o,
  output etwd_pkg::etwd_op_t        op_o
);

  assign item_stall_o = q_full_i;
  assign push_o       = item_valid_i && !q_full_i;

  always_comb begin
    op_o.toggle = 1'b0;
    if (item_i.command == etwd_pkg::CmdTick) begin
      op_o.kind = etwd_pkg::OP_TICK;
    end else begin
      // A pressed button reads low.
      op_o.toggle = !item_i.button_level;
      if (!item_i.a_level) begin
        op_o.kind = etwd_pkg::OP_HOLD;
      end else if (item_i.b_level) begin
        op_o.kind = etwd_pkg::OP_DOWN;
      end else begin
        op_o.kind = etwd_pkg::OP_UP;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/etwd_queue.sv @@
// Short operation queue between the front end and the back end.
// Depends on etwd_pkg and the shared assertion macros.
`default_nettype none
`include "encoder_tunable_white_dimmer_macros.svh"

module etwd_queue (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire etwd_pkg::etwd_op_t         op_i,
  input  wire logic                       pop_i,
  output etwd_pkg::etwd_op_t              op_o,
  output etwd_pkg::etwd_queue_stat_t      stat_o
);

  etwd_pkg::etwd_op_t entries_q [etwd_pkg::QueueDepth];
  logic [etwd_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [etwd_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [etwd_pkg::QueueCntW-1:0] count_q, count_d;

  localparam logic [etwd_pkg::QueuePtrW-1:0] LastPtr =
      etwd_pkg::QueuePtrW'(etwd_pkg::QueueDepth - 1);
  localparam logic [etwd_pkg::QueueCntW-1:0] FullCnt =
      etwd_pkg::QueueCntW'(etwd_pkg::QueueDepth);

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == FullCnt);
  assign op_o         = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= op_i;
    end
  end

  `ETWD_ASSERT(a_no_push_full, !(push_i && stat_o.full), "push into a full queue")
  `ETWD_ASSERT(a_no_pop_empty, !(pop_i && stat_o.empty), "pop from an empty queue")
  `ETWD_ASSERT(a_count_bound, count_q <= FullCnt, "queue count beyond depth")

endmodule

`default_nettype wire

@@ hw/rtl/etwd_div.sv @@
// Restoring divider, one quotient bit per cycle, for the channel map.
// Depends on etwd_pkg.
`default_nettype none

module etwd_div (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire etwd_pkg::etwd_div_req_t req_i,
  output etwd_pkg::etwd_div_rsp_t      rsp_o
);

  localparam logic [etwd_pkg::DivCntW-1:0] LastCnt =
      etwd_pkg::DivCntW'(etwd_pkg::DivW - 1);

  logic                          busy_q, done_q;
  logic [etwd_pkg::DivCntW-1:0]  cnt_q;
  logic [etwd_pkg::DivW-1:0]     quo_q;
  logic [7:0]                    rem_q;
  logic [7:0]                    div_q;
  logic [8:0]                    shifted;
  logic                          fits;

  // Dividend bits shift out of the top of quo_q as quotient bits enter below.
  assign shifted = {rem_q, quo_q[etwd_pkg::DivW-1]};
  assign fits    = (shifted >= {1'b0, div_q});

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[etwd_pkg::DivW-2:0], fits};
      rem_q <= fits ? 8'(shifted - {1'b0, div_q}) : shifted[7:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/etwd_back.sv @@
// Back end: register file, position and lamp update, channel map and ramp.
// Depends on etwd_pkg, etwd_div through its ports, and the assertion macros.
`default_nettype none
`include "encoder_tunable_white_dimmer_macros.svh"

module etwd_back (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [etwd_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [7:0]                           cfg_data_i,
  input  wire etwd_pkg::etwd_queue_stat_t           q_stat_i,
  input  wire etwd_pkg::etwd_op_t                   q_op_i,
  output logic                                      pop_o,
  output etwd_pkg::etwd_div_req_t                   div_req_o,
  input  wire etwd_pkg::etwd_div_rsp_t              div_rsp_i,
  output logic                                      result_valid_o,
  input  wire logic                                 result_stall_i,
  output etwd_pkg::etwd_result_t                    result_o
);

  etwd_pkg::etwd_state_e  state_q, state_d;
  etwd_pkg::etwd_cfg_t    cfg_q, cfg_d;
  etwd_pkg::etwd_op_t     op_q, op_d;
  etwd_pkg::etwd_result_t result_q, result_d;
  logic       result_valid_q, result_valid_d;
  logic [7:0] pos_q, pos_d;
  logic       lamp_q, lamp_d;
  logic [7:0] warm_lvl_q, warm_lvl_d, cool_lvl_q, cool_lvl_d;
  logic [7:0] warm_t_q, warm_t_d, cool_t_q, cool_t_d;
  logic       ch_q, ch_d;
  logic       neg_q, neg_d;

  // Position update.
  logic [7:0]        step;
  logic signed [9:0] pos_ext, step_ext, pos_sum, pos_clamp;
  logic              lamp_next;

  // Channel map.
  logic [7:0]        ch_start, ch_stop, start_diff, span_abs, out_abs;
  logic signed [8:0] span, out_span;
  logic [15:0]       numerator;
  logic signed [17:0] q_signed, mapped;
  logic [7:0]        mapped8;

  logic tgt_wr;
  logic [7:0] tgt_val;

  function automatic logic [7:0] slew(input logic [7:0] level, input logic [7:0] target);
    logic [7:0] r;
    r = level;
    if (target > level) begin
      r = level + 8'd1;
    end else if (target < level) begin
      r = level - 8'd1;
    end
    return r;
  endfunction

  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  assign step     = (pos_q >= cfg_q.step_threshold) ? cfg_q.high_step : cfg_q.low_step;
  assign pos_ext  = signed'({2'b00, pos_q});
  assign step_ext = signed'({2'b00, step});

  always_comb begin
    case (op_q.kind)
      etwd_pkg::OP_UP:   pos_sum = pos_ext + step_ext;
      etwd_pkg::OP_DOWN: pos_sum = pos_ext - step_ext;
      default:           pos_sum = pos_ext;
    endcase
    pos_clamp = pos_sum;
    if (pos_clamp < signed'({2'b00, etwd_pkg::MinPos8})) begin
      pos_clamp = signed'({2'b00, etwd_pkg::MinPos8});
    end
    if (pos_clamp > signed'({2'b00, cfg_q.position_max})) begin
      pos_clamp = signed'({2'b00, cfg_q.position_max});
    end
    if (pos_clamp < 10'sd0) begin
      pos_clamp = '0;
    end
    // Moving up turns the lamp on before the button toggles it.
    lamp_next = (op_q.kind == etwd_pkg::OP_UP) ? 1'b1 : lamp_q;
    if (op_q.toggle) begin
      lamp_next = !lamp_next;
    end
  end

  assign ch_start   = ch_q ? cfg_q.cool_start : cfg_q.warm_start;
  assign ch_stop    = ch_q ? cfg_q.cool_stop : cfg_q.warm_stop;
  assign span       = signed'({1'b0, ch_stop}) - signed'({1'b0, ch_start});
  assign span_abs   = span[8] ? 8'(-span) : span[7:0];
  assign out_span   = signed'({1'b0, cfg_q.position_max}) - signed'({1'b0, etwd_pkg::MinPos8});
  assign out_abs    = out_span[8] ? 8'(-out_span) : out_span[7:0];
  assign start_diff = pos_q - ch_start;
  assign numerator  = {8'b0, start_diff} * {8'b0, out_abs};

  // The divider works on magnitudes; the sign is put back here, which gives
  // truncation toward zero.
  always_comb begin
    q_signed = signed'({2'b00, div_rsp_i.quotient});
    mapped   = neg_q ? -q_signed : q_signed;
    mapped   = mapped + signed'({10'b0, etwd_pkg::MinPos8});
    if (mapped < 18'sd0) begin
      mapped8 = 8'd0;
    end else if (mapped > 18'sd255) begin
      mapped8 = 8'd255;
    end else begin
      mapped8 = mapped[7:0];
    end
  end

  always_comb begin
    state_d        = state_q;
    cfg_d          = cfg_q;
    op_d           = op_q;
    result_d       = result_q;
    result_valid_d = result_valid_q;
    pos_d          = pos_q;
    lamp_d         = lamp_q;
    warm_lvl_d     = warm_lvl_q;
    cool_lvl_d     = cool_lvl_q;
    warm_t_d       = warm_t_q;
    cool_t_d       = cool_t_q;
    ch_d           = ch_q;
    neg_d          = neg_q;
    pop_o          = 1'b0;
    tgt_wr         = 1'b0;
    tgt_val        = 8'd0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = numerator;
    div_req_o.divisor  = span_abs;

    if (cfg_valid_i) begin
      case (etwd_pkg::etwd_cfg_idx_e'(cfg_index_i))
        etwd_pkg::CFG_POSITION_MAX:   cfg_d.position_max   = cfg_data_i;
        etwd_pkg::CFG_LOW_STEP:       cfg_d.low_step       = cfg_data_i;
        etwd_pkg::CFG_HIGH_STEP:      cfg_d.high_step      = cfg_data_i;
        etwd_pkg::CFG_STEP_THRESHOLD: cfg_d.step_threshold = cfg_data_i;
        etwd_pkg::CFG_WARM_START:     cfg_d.warm_start     = cfg_data_i;
        etwd_pkg::CFG_WARM_STOP:      cfg_d.warm_stop      = cfg_data_i;
        etwd_pkg::CFG_COOL_START:     cfg_d.cool_start     = cfg_data_i;
        etwd_pkg::CFG_COOL_STOP:      cfg_d.cool_stop      = cfg_data_i;
        default: ;
      endcase
    end

    if (result_valid_q && !result_stall_i) begin
      result_valid_d = 1'b0;
    end

    case (state_q)
      etwd_pkg::S_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          op_d    = q_op_i;
          state_d = etwd_pkg::S_APPLY;
        end
      end
      etwd_pkg::S_APPLY: begin
        // A tick leaves the position alone, so it is not clamped either.
        if (op_q.kind != etwd_pkg::OP_TICK) begin
          pos_d = pos_clamp[7:0];
        end
        lamp_d  = lamp_next;
        ch_d    = 1'b0;
        state_d = etwd_pkg::S_CH_START;
      end
      etwd_pkg::S_CH_START: begin
        if (!lamp_q || (pos_q < ch_start)) begin
          tgt_wr  = 1'b1;
          tgt_val = 8'd0;
        end else if (span == 9'sd0) begin
          tgt_wr  = 1'b1;
          tgt_val = 8'd255;
        end else begin
          div_req_o.start = 1'b1;
          neg_d   = span[8] ^ out_span[8];
          state_d = etwd_pkg::S_CH_WAIT;
        end
      end
      etwd_pkg::S_CH_WAIT: begin
        if (div_rsp_i.done) begin
          tgt_wr  = 1'b1;
          tgt_val = mapped8;
        end
      end
      etwd_pkg::S_DONE: begin
        if (!result_valid_q || !result_stall_i) begin
          if (op_q.kind == etwd_pkg::OP_TICK) begin
            warm_lvl_d = slew(warm_lvl_q, warm_t_q);
            cool_lvl_d = slew(cool_lvl_q, cool_t_q);
          end
          result_d.position    = pos_q;
          result_d.lamp_on     = lamp_q;
          result_d.warm_target = warm_t_q;
          result_d.cool_target = cool_t_q;
          result_d.warm_level  = warm_lvl_d;
          result_d.cool_level  = cool_lvl_d;
          result_valid_d       = 1'b1;
          state_d              = etwd_pkg::S_IDLE;
        end
      end
      default: state_d = etwd_pkg::S_IDLE;
    endcase

    if (tgt_wr) begin
      if (ch_q) begin
        cool_t_d = tgt_val;
        state_d  = etwd_pkg::S_DONE;
      end else begin
        warm_t_d = tgt_val;
        ch_d     = 1'b1;
        state_d  = etwd_pkg::S_CH_START;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= etwd_pkg::S_IDLE;
      cfg_q          <= etwd_pkg::CfgReset;
      result_valid_q <= 1'b0;
      pos_q          <= '0;
      lamp_q         <= 1'b1;
      warm_lvl_q     <= '0;
      cool_lvl_q     <= '0;
      ch_q           <= 1'b0;
    end else begin
      state_q        <= state_d;
      cfg_q          <= cfg_d;
      result_valid_q <= result_valid_d;
      pos_q          <= pos_d;
      lamp_q         <= lamp_d;
      warm_lvl_q     <= warm_lvl_d;
      cool_lvl_q     <= cool_lvl_d;
      ch_q           <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    result_q <= result_d;
    warm_t_q <= warm_t_d;
    cool_t_q <= cool_t_d;
    neg_q    <= neg_d;
  end

  `ETWD_ASSERT(a_div_start_idle, !(div_req_o.start && div_rsp_i.busy), "divider started while busy")
  `ETWD_ASSERT_NEXT(a_done_waits, (state_q == etwd_pkg::S_DONE) && result_valid_q && result_stall_i, state_q == etwd_pkg::S_DONE, "result register overwritten while held")
  `ETWD_ASSERT_NEXT(a_up_lamp_on, (state_q == etwd_pkg::S_APPLY) && (op_q.kind == etwd_pkg::OP_UP) && !op_q.toggle, lamp_q, "upward move left the lamp off")

endmodule

`default_nettype wire

@@ verif/tb_encoder_tunable_white_dimmer.sv @@
// Self-checking bench for the encoder tunable-white dimmer: pin-change and tick words go in
// with random idling on both sides, and every result word is predicted and checked by field.
// Depends on etwd_pkg and the encoder_tunable_white_dimmer RTL; reads no files.

import etwd_pkg::*;

class dimmer_tracker;
  logic [7:0]   regs [8];
  logic [7:0]   position;
  logic         lamp;
  logic [7:0]   warm_level;
  logic [7:0]   cool_level;
  etwd_result_t expected_words [$];
  int unsigned  faults;
  int unsigned  words_seen;

  function new();
    regs[CFG_POSITION_MAX]   = CfgReset.position_max;
    regs[CFG_LOW_STEP]       = CfgReset.low_step;
    regs[CFG_HIGH_STEP]      = CfgReset.high_step;
    regs[CFG_STEP_THRESHOLD] = CfgReset.step_threshold;
    regs[CFG_WARM_START]     = CfgReset.warm_start;
    regs[CFG_WARM_STOP]      = CfgReset.warm_stop;
    regs[CFG_COOL_START]     = CfgReset.cool_start;
    regs[CFG_COOL_STOP]      = CfgReset.cool_stop;
    position   = 8'd0;
    lamp       = 1'b1;
    warm_level = 8'd0;
    cool_level = 8'd0;
    faults     = 0;
    words_seen = 0;
  endfunction

  function void set_reg(etwd_cfg_idx_e idx, logic [7:0] value);
    regs[idx] = value;
  endfunction

  // Linear map of the position from start..stop onto MinPosition..position_max.
  // Division truncates toward zero, so a reversed span yields a negative value.
  function logic [7:0] map_target(logic [7:0] start, logic [7:0] stop);
    int offset;
    int span;
    int out_span;
    int v;
    offset   = int'(position) - int'(start);
    span     = int'(stop) - int'(start);
    out_span = int'(regs[CFG_POSITION_MAX]) - int'(MinPosition);
    if (!lamp || offset < 0) return 8'd0;
    if (span == 0) return 8'd255;
    v = (offset * out_span) / span + int'(MinPosition);
    if (v > 255) v = 255;
    if (v < 0) v = 0;
    return 8'(v);
  endfunction

  function logic [7:0] slew_toward(logic [7:0] level, logic [7:0] target);
    if (target > level) return level + 8'd1;
    if (target < level) return level - 8'd1;
    return level;
  endfunction

  function void note_word(etwd_item_t w);
    etwd_result_t r;
    int pos;
    int step;
    logic [7:0] warm_t;
    logic [7:0] cool_t;
    if (w.command != CmdTick) begin
      pos  = int'(position);
      step = (position >= regs[CFG_STEP_THRESHOLD]) ? int'(regs[CFG_HIGH_STEP])
                                                     : int'(regs[CFG_LOW_STEP]);
      if (w.a_level) begin
        if (!w.b_level) begin
          pos  = pos + step;
          lamp = 1'b1;
        end else begin
          pos = pos - step;
        end
      end
      if (!w.button_level) lamp = !lamp;
      // The lower clamp comes first, so a zero position_max always wins.
      if (pos < int'(MinPosition)) pos = int'(MinPosition);
      if (pos > int'(regs[CFG_POSITION_MAX])) pos = int'(regs[CFG_POSITION_MAX]);
      if (pos < 0) pos = 0;
      position = 8'(pos);
    end
    warm_t = map_target(regs[CFG_WARM_START], regs[CFG_WARM_STOP]);
    cool_t = map_target(regs[CFG_COOL_START], regs[CFG_COOL_STOP]);
    if (w.command == CmdTick) begin
      warm_level = slew_toward(warm_level, warm_t);
      cool_level = slew_toward(cool_level, cool_t);
    end
    r.position    = position;
    r.lamp_on     = lamp;
    r.warm_target = warm_t;
    r.cool_target = cool_t;
    r.warm_level  = warm_level;
    r.cool_level  = cool_level;
    expected_words.push_back(r);
  endfunction

  function void check_word(etwd_result_t got);
    etwd_result_t want;
    words_seen++;
    if (expected_words.size() == 0) begin
      faults++;
      if (faults <= 10) begin
        $display("word %0d: result with nothing pending: pos %0d lamp %0b", words_seen,
                 got.position, got.lamp_on);
      end
      return;
    end
    want = expected_words.pop_front();
    if (got.position !== want.position || got.lamp_on !== want.lamp_on ||
        got.warm_target !== want.warm_target || got.cool_target !== want.cool_target ||
        got.warm_level !== want.warm_level || got.cool_level !== want.cool_level) begin
      faults++;
      if (faults <= 10) begin
        $display("word %0d: expected pos %0d lamp %0b wt %0d ct %0d wl %0d cl %0d",
                 words_seen, want.position, want.lamp_on, want.warm_target,
                 want.cool_target, want.warm_level, want.cool_level);
        $display("word %0d: actual   pos %0d lamp %0b wt %0d ct %0d wl %0d cl %0d",
                 words_seen, got.position, got.lamp_on, got.warm_target,
                 got.cool_target, got.warm_level, got.cool_level);
      end
    end
  endfunction
endclass

module tb_encoder_tunable_white_dimmer;
  localparam logic CmdPinChange = ~CmdTick;
  localparam int   SettleCycles = 50;
  localparam int   HoldCycles   = 150;
  localparam int   PhaseWords   = 100;

  logic                clk          = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                item_valid   = 1'b0;
  logic                item_stall;
  etwd_item_t          item_word    = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  etwd_result_t        result_word;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index    = CFG_POSITION_MAX;
  logic [7:0]          cfg_data     = 8'd0;

  bit            idle_on      = 1'b1;
  bit            hold_request = 1'b0;
  dimmer_tracker tracker;

  encoder_tunable_white_dimmer u_top (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_stall_o   (item_stall),
    .item_i         (item_word),
    .result_valid_o (result_valid),
    .result_stall_i (result_stall),
    .result_o       (result_word),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("encoder_tunable_white_dimmer: mismatch");
    $finish;
  end

  // Result side: checks every accepted word and stalls in random bursts. A long hold,
  // requested by the stimulus, is counted down here so that the input side fills up.
  initial begin : result_side
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_ni && result_valid && !result_stall) tracker.check_word(result_word);
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  function automatic etwd_item_t word_of(logic cmd, logic a, logic b, logic button);
    etwd_item_t w;
    w.command      = cmd;
    w.a_level      = a;
    w.b_level      = b;
    w.button_level = button;
    return w;
  endfunction

  function automatic etwd_item_t random_word();
    etwd_item_t w;
    w = etwd_item_t'(4'($urandom));
    if ($urandom_range(0, 99) < 35) begin
      w.command = CmdTick;
    end else begin
      w.command      = CmdPinChange;
      w.a_level      = ($urandom_range(0, 4) != 0);
      w.button_level = ($urandom_range(0, 7) != 0);
    end
    return w;
  endfunction

  function automatic logic [7:0] random_reg();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] random_step();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(1, 12));
    return random_reg();
  endfunction

  // Valid stays high across back-to-back words; it drops for an idle gap or while the bench drains.
  task automatic send_word(etwd_item_t w);
    item_valid <= 1'b1;
    item_word  <= w;
    do @(posedge clk); while (item_stall);
    tracker.note_word(w);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] vals [8]);
    etwd_cfg_idx_e idx;
    for (int i = 0; i < 8; i++) begin
      idx = etwd_cfg_idx_e'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[idx];
      do @(posedge clk); while (!cfg_ready);
      tracker.set_reg(idx, vals[idx]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] setting [8];
    tracker = new();
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Reset values written back explicitly.
    setting[CFG_POSITION_MAX]   = CfgReset.position_max;
    setting[CFG_LOW_STEP]       = CfgReset.low_step;
    setting[CFG_HIGH_STEP]      = CfgReset.high_step;
    setting[CFG_STEP_THRESHOLD] = CfgReset.step_threshold;
    setting[CFG_WARM_START]     = CfgReset.warm_start;
    setting[CFG_WARM_STOP]      = CfgReset.warm_stop;
    setting[CFG_COOL_START]     = CfgReset.cool_start;
    setting[CFG_COOL_STOP]      = CfgReset.cool_stop;
    write_regs(setting);

    // Ticks ignore the pin fields; A low only lets the button act.
    send_word(word_of(CmdTick, 1'b1, 1'b1, 1'b0));
    send_word(word_of(CmdTick, 1'b0, 1'b0, 1'b1));
    send_word(word_of(CmdPinChange, 1'b0, 1'b0, 1'b1));
    send_word(word_of(CmdPinChange, 1'b0, 1'b1, 1'b1));
    send_word(word_of(CmdPinChange, 1'b1, 1'b0, 1'b1));
    send_word(word_of(CmdPinChange, 1'b1, 1'b0, 1'b1));
    send_word(word_of(CmdPinChange, 1'b1, 1'b1, 1'b1));
    send_word(word_of(CmdPinChange, 1'b0, 1'b1, 1'b0));
    send_word(word_of(CmdTick, 1'b1, 1'b0, 1'b1));
    // An up move with the button low forces the lamp on and then toggles it off.
    send_word(word_of(CmdPinChange, 1'b1, 1'b0, 1'b0));
    send_word(word_of(CmdPinChange, 1'b1, 1'b1, 1'b0));
    send_word(word_of(CmdPinChange, 1'b1, 1'b1, 1'b1));
    send_word(word_of(CmdPinChange, 1'b1, 1'b1, 1'b1));
    send_word(word_of(CmdTick, 1'b0, 1'b1, 1'b0));
    wait_drained();

    // Zero position_max, full steps, equal warm endpoints, reversed cool span.
    setting[CFG_POSITION_MAX]   = 8'd0;
    setting[CFG_LOW_STEP]       = 8'd255;
    setting[CFG_HIGH_STEP]      = 8'd255;
    setting[CFG_STEP_THRESHOLD] = 8'd0;
    setting[CFG_WARM_START]     = 8'd0;
    setting[CFG_WARM_STOP]      = 8'd0;
    setting[CFG_COOL_START]     = 8'd255;
    setting[CFG_COOL_STOP]      = 8'd0;
    write_regs(setting);
    send_word(word_of(CmdPinChange, 1'b1, 1'b0, 1'b1));
    send_word(word_of(CmdTick, 1'b0, 1'b0, 1'b0));
    send_word(word_of(CmdPinChange, 1'b1, 1'b1, 1'b0));
    send_word(word_of(CmdTick, 1'b1, 1'b1, 1'b1));
    send_word(word_of(CmdPinChange, 1'b0, 1'b0, 1'b0));
    wait_drained();

    // Clamp at the top, zero high step, warm span reversed above its start.
    setting[CFG_POSITION_MAX]   = 8'd255;
    setting[CFG_LOW_STEP]       = 8'd255;
    setting[CFG_HIGH_STEP]      = 8'd0;
    setting[CFG_STEP_THRESHOLD] = 8'd255;
    setting[CFG_WARM_START]     = 8'd100;
    setting[CFG_WARM_STOP]      = 8'd20;
    setting[CFG_COOL_START]     = 8'd0;
    setting[CFG_COOL_STOP]      = 8'd255;
    write_regs(setting);
    send_word(word_of(CmdPinChange, 1'b1, 1'b0, 1'b1));
    send_word(word_of(CmdPinChange, 1'b1, 1'b0, 1'b1));
    send_word(word_of(CmdTick, 1'b0, 1'b0, 1'b1));
    send_word(word_of(CmdPinChange, 1'b1, 1'b1, 1'b1));
    send_word(word_of(CmdTick, 1'b0, 1'b0, 1'b1));
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        setting[CFG_POSITION_MAX]   = 8'd200;
        setting[CFG_LOW_STEP]       = 8'd3;
        setting[CFG_HIGH_STEP]      = 8'd9;
        setting[CFG_STEP_THRESHOLD] = 8'd60;
        setting[CFG_WARM_START]     = 8'd10;
        setting[CFG_WARM_STOP]      = 8'd150;
        setting[CFG_COOL_START]     = 8'd90;
        setting[CFG_COOL_STOP]      = 8'd240;
      end else begin
        setting[CFG_POSITION_MAX]   = random_reg();
        setting[CFG_LOW_STEP]       = random_step();
        setting[CFG_HIGH_STEP]      = random_step();
        setting[CFG_STEP_THRESHOLD] = random_reg();
        setting[CFG_WARM_START]     = random_reg();
        setting[CFG_WARM_STOP]      = random_reg();
        setting[CFG_COOL_START]     = random_reg();
        setting[CFG_COOL_STOP]      = random_reg();
      end
      write_regs(setting);
      // The final phase runs with no idling at all.
      idle_on = (phase != 5);
      if (phase == 2) hold_request = 1'b1;
      for (int n = 0; n < PhaseWords; n++) begin
        if (phase == 3 && n == PhaseWords / 2) wait_drained();
        send_word(random_word());
      end
      wait_drained();
    end

    if (tracker.faults == 0 && tracker.expected_words.size() == 0) begin
      $display("encoder_tunable_white_dimmer: match");
    end else begin
      $display("encoder_tunable_white_dimmer: mismatch");
    end
    $finish;
  end
endmodule
